>>> design/dvrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrc_pkg: shared types and constants of the device value response curve
// Holds the item and result layouts, the configuration record, the queue
// entry passed from the front end to the back end, and the sizing constants.
// ----------------------------------------------------------------------------
package dvrc_pkg;

    // Table and scale sizing.
    localparam int MAX_POINTS  = 16;
    localparam int FULL_SCALE  = 10000;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int VAL_W       = 14;
    localparam int RAW_W       = 32;
    localparam int CNT_PT_W    = 5;

    // Datapath widths: a 33-bit difference times the 14-bit scale.
    localparam int WIDE_W      = RAW_W + 1;
    localparam int PROD_W      = WIDE_W + VAL_W;

    // Depth of the queue between front end and back end.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd3;

    // Item operation codes.
    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    // One input transaction.
    typedef struct packed {
        op_t                     operation;
        logic signed [RAW_W-1:0] raw_value;
        logic [IDX_W-1:0]        point_index;
        logic [VAL_W-1:0]        point_x;
        logic [VAL_W-1:0]        point_y;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [VAL_W-1:0] position;
        logic [VAL_W-1:0] curve_value;
        logic             range_error;
    } result_t;

    // Configuration registers.
    typedef struct packed {
        logic signed [RAW_W-1:0] device_min;
        logic signed [RAW_W-1:0] device_max;
        logic                    reverse;
        logic [CNT_PT_W-1:0]     point_count;
    } cfg_t;

    // Classified item waiting for the back end; point values already saturated.
    typedef struct packed {
        op_t                     kind;
        logic signed [RAW_W-1:0] raw_value;
        logic [IDX_W-1:0]        point_index;
        logic [VAL_W-1:0]        point_x;
        logic [VAL_W-1:0]        point_y;
    } queue_entry_t;

    // Saturate a 14-bit value to full scale.
    function automatic logic [VAL_W-1:0] sat_full(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] limit;
        limit = VAL_W'(FULL_SCALE);
        return (v > limit) ? limit : v;
    endfunction

endpackage

>>> design/dvrc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrc_front: command intake and classification queue
// Accepts input transactions, saturates point values, and holds classified
// entries in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module dvrc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  dvrc_pkg::in_item_t     item,
    output logic                   busy,
    output logic                   q_valid,
    output dvrc_pkg::queue_entry_t q_entry,
    input  logic                   q_pop
);
    import dvrc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t     entry_reg [QUEUE_DEPTH];
    queue_entry_t     new_entry;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    // The queue refuses a new transaction only while it is full.
    assign busy    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_entry = entry_reg[rd_ptr_reg];

    // Classify the incoming item and saturate its point values.
    always_comb
    begin
        new_entry.kind        = item.operation;
        new_entry.raw_value   = item.raw_value;
        new_entry.point_index = item.point_index;
        new_entry.point_x     = sat_full(item.point_x);
        new_entry.point_y     = sat_full(item.point_y);
    end

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push  ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (!push && q_pop)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above its depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("accepted transaction not counted in the queue");
`endif

endmodule

>>> design/dvrc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrc_div: shared radix-2 restoring divider
// Produces a 14-bit quotient in 14 steps, one bit per cycle. The dividend
// shifted right by 14 must be below the divisor, which both callers ensure.
// ----------------------------------------------------------------------------
module dvrc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [dvrc_pkg::PROD_W-1:0]  dividend,
    input  logic [dvrc_pkg::WIDE_W-1:0]  divisor,
    output logic [dvrc_pkg::VAL_W-1:0]   quotient,
    output logic                         done
);
    import dvrc_pkg::*;

    localparam int STEP_W = $clog2(VAL_W);

    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] den_reg;
    logic [VAL_W-1:0]  low_reg;
    logic [VAL_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic [WIDE_W:0]   shifted;
    logic [WIDE_W+1:0] trial;
    logic              fits;

    // Trial subtraction for the next quotient bit.
    assign shifted = {rem_reg, low_reg[VAL_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = !trial[WIDE_W+1];

    assign quotient = quo_reg;
    assign done     = done_reg;

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= STEP_W'(step_reg + 1'b1);
                if (step_reg == STEP_W'(VAL_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[PROD_W-1:VAL_W];
            low_reg <= dividend[VAL_W-1:0];
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? trial[WIDE_W-1:0] : shifted[WIDE_W-1:0];
            low_reg <= {low_reg[VAL_W-2:0], 1'b0};
            quo_reg <= {quo_reg[VAL_W-2:0], fits};
        end
    end

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("divider restarted while a division is running");
`endif

endmodule

>>> design/dvrc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvrc_back: execution sequencer of the response curve
// Writes control points, normalizes samples, scans the point table one entry
// per cycle and interpolates with the shared multiplier and divider.
// ----------------------------------------------------------------------------
module dvrc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dvrc_pkg::cfg_t         cfg,
    input  logic                   q_valid,
    input  dvrc_pkg::queue_entry_t q_entry,
    output logic                   q_pop,
    output logic                   done,
    output dvrc_pkg::result_t      result
);
    import dvrc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_NORM      = 8'b0000_0010,
        ST_POS_GO    = 8'b0000_0100,
        ST_NDIV_WAIT = 8'b0000_1000,
        ST_SCAN_GO   = 8'b0001_0000,
        ST_SCAN      = 8'b0010_0000,
        ST_CDIV_GO   = 8'b0100_0000,
        ST_CDIV_WAIT = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic [WIDE_W-1:0] num_reg, num_next;
    logic [WIDE_W-1:0] den_reg, den_next;
    logic [WIDE_W-1:0] mag_num, mag_den;
    logic              sat_reg, sat_next;
    logic              neg_reg, neg_next;
    logic [WIDE_W-1:0] div_den_reg, div_den_next;
    logic [VAL_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic [VAL_W-1:0]  x0_reg, x0_next;
    logic [VAL_W-1:0]  y0_reg, y0_next;

    logic [WIDE_W-1:0] mul_a;
    logic [VAL_W-1:0]  mul_b;
    logic              prod_en;
    logic [PROD_W-1:0] prod_reg;

    logic              tbl_we;
    logic [VAL_W-1:0]  curve_x_table [MAX_POINTS];
    logic [VAL_W-1:0]  curve_y_table [MAX_POINTS];
    logic [VAL_W-1:0]  x_rd_reg;
    logic [VAL_W-1:0]  y_rd_reg;

    logic [VAL_W-1:0]  dx;
    logic [VAL_W-1:0]  dy_mag;
    logic              dy_neg;

    logic              div_start;
    logic              div_done;
    logic [VAL_W-1:0]  div_q;

    // Clamp a signed intermediate to 0..full scale.
    function automatic logic [VAL_W-1:0] clamp_full(input logic signed [VAL_W+2:0] s);
        logic [VAL_W-1:0] res;
        if (s < 0)
        begin
            res = '0;
        end
        else if (s > $signed((VAL_W+3)'(FULL_SCALE)))
        begin
            res = VAL_W'(FULL_SCALE);
        end
        else
        begin
            res = s[VAL_W-1:0];
        end
        return res;
    endfunction

    // Signed quotient, optional mirror, then clamp.
    function automatic logic [VAL_W-1:0] pos_from_quot(input logic [VAL_W-1:0] q,
                                                       input logic neg,
                                                       input logic rev);
        logic signed [VAL_W+2:0] s;
        s = $signed({3'b000, q});
        if (neg)
        begin
            s = -s;
        end
        if (rev)
        begin
            s = $signed((VAL_W+3)'(FULL_SCALE)) - s;
        end
        return clamp_full(s);
    endfunction

    // Interpolated value y0 plus or minus the quotient, then clamp.
    function automatic logic [VAL_W-1:0] curve_from_quot(input logic [VAL_W-1:0] y0,
                                                         input logic [VAL_W-1:0] q,
                                                         input logic neg);
        logic signed [VAL_W+2:0] s;
        if (neg)
        begin
            s = $signed({3'b000, y0}) - $signed({3'b000, q});
        end
        else
        begin
            s = $signed({3'b000, y0}) + $signed({3'b000, q});
        end
        return clamp_full(s);
    endfunction

    // Magnitudes of the normalization difference and range.
    assign mag_num = num_reg[WIDE_W-1] ? WIDE_W'(~num_reg + 1'b1) : num_reg;
    assign mag_den = den_reg[WIDE_W-1] ? WIDE_W'(~den_reg + 1'b1) : den_reg;

    // Index of the last point in use: zero counts as one, large counts saturate.
    always_comb
    begin
        if (cfg.point_count == '0)
        begin
            last_idx = '0;
        end
        else if (cfg.point_count > CNT_PT_W'(MAX_POINTS))
        begin
            last_idx = IDX_W'(MAX_POINTS - 1);
        end
        else
        begin
            last_idx = IDX_W'(cfg.point_count - 1'b1);
        end
    end

    // Segment deltas against the previously scanned point.
    assign dx     = VAL_W'(pos_reg - x0_reg);
    assign dy_neg = (y_rd_reg < y0_reg);
    assign dy_mag = dy_neg ? VAL_W'(y0_reg - y_rd_reg) : VAL_W'(y_rd_reg - y0_reg);

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        sat_next     = sat_reg;
        neg_next     = neg_reg;
        div_den_next = div_den_reg;
        pos_next     = pos_reg;
        cmp_idx_next = cmp_idx_reg;
        x0_next      = x0_reg;
        y0_next      = y0_reg;
        q_pop        = 1'b0;
        tbl_we       = 1'b0;
        div_start    = 1'b0;
        prod_en      = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        rd_addr      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_entry.kind == OP_WRITE)
                    begin
                        tbl_we = 1'b1;
                    end
                    else
                    begin
                        num_next   = {q_entry.raw_value[RAW_W-1], q_entry.raw_value}
                                   - {cfg.device_min[RAW_W-1], cfg.device_min};
                        den_next   = {cfg.device_max[RAW_W-1], cfg.device_max}
                                   - {cfg.device_min[RAW_W-1], cfg.device_min};
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM:
            begin
                if (den_reg == '0)
                begin
                    // Equal range limits: flag the error with zero fields.
                    done_next               = 1'b1;
                    result_next.position    = '0;
                    result_next.curve_value = '0;
                    result_next.range_error = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    mul_a        = mag_num;
                    mul_b        = VAL_W'(FULL_SCALE);
                    prod_en      = 1'b1;
                    sat_next     = (mag_num >= mag_den);
                    neg_next     = num_reg[WIDE_W-1] ^ den_reg[WIDE_W-1];
                    div_den_next = mag_den;
                    state_next   = ST_POS_GO;
                end
            end
            ST_POS_GO:
            begin
                // A quotient at or beyond full scale clamps the same as full scale.
                if (sat_reg)
                begin
                    pos_next   = pos_from_quot(VAL_W'(FULL_SCALE), neg_reg, cfg.reverse);
                    state_next = ST_SCAN_GO;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_NDIV_WAIT;
                end
            end
            ST_NDIV_WAIT:
            begin
                if (div_done)
                begin
                    pos_next   = pos_from_quot(div_q, neg_reg, cfg.reverse);
                    state_next = ST_SCAN_GO;
                end
            end
            ST_SCAN_GO:
            begin
                rd_addr      = '0;
                cmp_idx_next = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Read data holds the entry at cmp_idx; fetch the next one meanwhile.
                rd_addr = IDX_W'(cmp_idx_reg + 1'b1);
                if (pos_reg < x_rd_reg)
                begin
                    if ((cmp_idx_reg == '0) || (x_rd_reg == x0_reg))
                    begin
                        done_next               = 1'b1;
                        result_next.position    = pos_reg;
                        result_next.curve_value = y_rd_reg;
                        result_next.range_error = 1'b0;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        mul_a        = WIDE_W'(dx);
                        mul_b        = dy_mag;
                        prod_en      = 1'b1;
                        neg_next     = dy_neg;
                        div_den_next = WIDE_W'(VAL_W'(x_rd_reg - x0_reg));
                        state_next   = ST_CDIV_GO;
                    end
                end
                else
                begin
                    x0_next = x_rd_reg;
                    y0_next = y_rd_reg;
                    if (cmp_idx_reg == last_idx)
                    begin
                        // Past the last point: its value holds.
                        done_next               = 1'b1;
                        result_next.position    = pos_reg;
                        result_next.curve_value = y_rd_reg;
                        result_next.range_error = 1'b0;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        cmp_idx_next = IDX_W'(cmp_idx_reg + 1'b1);
                    end
                end
            end
            ST_CDIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_CDIV_WAIT;
            end
            ST_CDIV_WAIT:
            begin
                if (div_done)
                begin
                    done_next               = 1'b1;
                    result_next.position    = pos_reg;
                    result_next.curve_value = curve_from_quot(y0_reg, div_q, neg_reg);
                    result_next.range_error = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers and the shared multiplier.
    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        sat_reg     <= sat_next;
        neg_reg     <= neg_next;
        div_den_reg <= div_den_next;
        pos_reg     <= pos_next;
        cmp_idx_reg <= cmp_idx_next;
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
        if (prod_en)
        begin
            prod_reg <= {{VAL_W{1'b0}}, mul_a} * {{WIDE_W{1'b0}}, mul_b};
        end
    end

    // Point tables: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            curve_x_table[q_entry.point_index] <= q_entry.point_x;
            curve_y_table[q_entry.point_index] <= q_entry.point_y;
        end
        x_rd_reg <= curve_x_table[rd_addr];
        y_rd_reg <= curve_y_table[rd_addr];
    end

    dvrc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (div_den_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.range_error) |->
            ((result_reg.position == '0) && (result_reg.curve_value == '0)))
        else $error("range error result carries nonzero fields");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (($past(state_reg) == ST_NORM) || ($past(state_reg) == ST_SCAN)
                      || ($past(state_reg) == ST_CDIV_WAIT)))
        else $error("result strobe from a state that produces no result");
`endif

endmodule

>>> design/device_value_response_curve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_value_response_curve: response curve for raw input-device readings
// Holds the configuration registers and joins the intake queue to the
// execution sequencer. Point writes store one control point; samples return
// a normalized position and the interpolated curve value.
// ----------------------------------------------------------------------------
// Sequence: a valid sample passes normalization, a 14-step division, the point
// scan of one table entry per cycle and a second 14-step division before done;
// either division may be skipped. One transaction at a time in the sequencer;
// the two-entry queue takes new transactions while it works, until it is full.
// The receiver cannot stall: done is high for a single cycle per result.
// Reset clears control state and restores register defaults; tables are not cleared.
module device_value_response_curve (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  dvrc_pkg::in_item_t              item,
    output logic                            done,
    output dvrc_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [dvrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dvrc_pkg::RAW_W-1:0]      cfg_data
);
    import dvrc_pkg::*;

    cfg_t         cfg_reg;
    logic         q_valid;
    logic         q_pop;
    queue_entry_t q_entry;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_min  <= '0;
            cfg_reg.device_max  <= RAW_W'(1024);
            cfg_reg.reverse     <= 1'b0;
            cfg_reg.point_count <= CNT_PT_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_MIN:  cfg_reg.device_min  <= $signed(cfg_data);
                CFG_DEVICE_MAX:  cfg_reg.device_max  <= $signed(cfg_data);
                CFG_REVERSE:     cfg_reg.reverse     <= cfg_data[0];
                CFG_POINT_COUNT: cfg_reg.point_count <= cfg_data[CNT_PT_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    dvrc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    dvrc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

endmodule
